/* design/ddd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ddd_pkg
// Shared types, widths and calendar tables for the date difference pipeline.
// ----------------------------------------------------------------------------
package ddd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int MTERM_W  = 9;
    localparam int COUNT_W  = 24;
    localparam int DIFF_W   = 23;

    // x / 100 == (x * 5243) >> 19, exact for every x below 2**14
    localparam int RECIP_100   = 5243;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = 27;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    localparam int DAYS_PER_YEAR = 365;
    localparam int DIFF_LIMIT    = 3660000;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_MONTH = 2'd1,
        STATUS_BAD_DAY   = 2'd2
    } status_t;

    typedef struct packed {
        logic s1;
        logic s2;
    } stage_en_t;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [DAY_W-1:0]   DAY_LEAP  = 5'd29;

    // Longest day of each month, February at its leap value; 0 for bad codes
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd29;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of the month in a year that starts on March 1
    function automatic logic [MTERM_W-1:0] month_term(input logic [MONTH_W-1:0] m);
        logic [MTERM_W-1:0] t;
        unique case (m)
            4'd3:    t = 9'd0;
            4'd4:    t = 9'd31;
            4'd5:    t = 9'd61;
            4'd6:    t = 9'd92;
            4'd7:    t = 9'd122;
            4'd8:    t = 9'd153;
            4'd9:    t = 9'd184;
            4'd10:   t = 9'd214;
            4'd11:   t = 9'd245;
            4'd12:   t = 9'd275;
            4'd1:    t = 9'd306;
            4'd2:    t = 9'd337;
            default: t = 9'd0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

/* design/ddd_date_conv.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ddd_date_conv
// Two-stage date check and day count for one date of the pair.
// ----------------------------------------------------------------------------
module ddd_date_conv (
    input  wire logic                               clk,
    input  wire ddd_pkg::stage_en_t                 ctrl,
    input  wire logic [ddd_pkg::YEAR_W-1:0]         year,
    input  wire logic [ddd_pkg::MONTH_W-1:0]        month,
    input  wire logic [ddd_pkg::DAY_W-1:0]          day,
    output ddd_pkg::status_t                        status,
    output logic signed [ddd_pkg::COUNT_W-1:0]      count
);

    // stage 1 registers
    logic                          month_bad_reg, month_bad_next;
    logic                          day_bad_reg, day_bad_next;
    logic                          feb29_reg, feb29_next;
    logic                          neg_reg, neg_next;
    logic [ddd_pkg::YEAR_W-1:0]    year_reg;
    logic [ddd_pkg::YEAR_W-1:0]    yy_reg, yy_next;
    logic [ddd_pkg::MTERM_W-1:0]   mterm_reg, mterm_next;
    logic [ddd_pkg::DAY_W-1:0]     day_reg;
    logic [ddd_pkg::PROD_W-1:0]    year_prod_reg, year_prod_next;
    logic [ddd_pkg::PROD_W-1:0]    yy_prod_reg, yy_prod_next;

    // stage 2 registers
    ddd_pkg::status_t                   status_reg, status_next;
    logic signed [ddd_pkg::COUNT_W-1:0] count_reg, count_next;

    logic [ddd_pkg::DAY_W-1:0]     len_w;
    logic                          late_w;

    always_comb
    begin
        len_w          = ddd_pkg::month_len(month);
        late_w         = month > ddd_pkg::MONTH_FEB;
        month_bad_next = (len_w == '0);
        day_bad_next   = (day == '0) || (day > len_w);
        feb29_next     = (month == ddd_pkg::MONTH_FEB) && (day == ddd_pkg::DAY_LEAP);
        // January and February belong to the previous year
        yy_next        = late_w ? year : year - ddd_pkg::YEAR_W'(1);
        neg_next       = !late_w && (year == '0);
        mterm_next     = ddd_pkg::month_term(month);
        year_prod_next = ddd_pkg::PROD_W'(year) * ddd_pkg::PROD_W'(ddd_pkg::RECIP_100);
        yy_prod_next   = ddd_pkg::PROD_W'(yy_next) * ddd_pkg::PROD_W'(ddd_pkg::RECIP_100);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s1)
        begin
            month_bad_reg <= month_bad_next;
            day_bad_reg   <= day_bad_next;
            feb29_reg     <= feb29_next;
            neg_reg       <= neg_next;
            year_reg      <= year;
            yy_reg        <= yy_next;
            mterm_reg     <= mterm_next;
            day_reg       <= day;
            year_prod_reg <= year_prod_next;
            yy_prod_reg   <= yy_prod_next;
        end
    end

    logic [ddd_pkg::QUOT_W-1:0]    q_year_w;
    logic [ddd_pkg::QUOT_W-1:0]    q_yy_w;
    logic [ddd_pkg::YEAR_W-1:0]    rem_year_w;
    logic                          leap_w;
    logic [ddd_pkg::COUNT_W-1:0]   tail_w;

    always_comb
    begin
        q_year_w   = year_prod_reg[ddd_pkg::PROD_W-1:ddd_pkg::RECIP_SHIFT];
        q_yy_w     = yy_prod_reg[ddd_pkg::PROD_W-1:ddd_pkg::RECIP_SHIFT];
        rem_year_w = year_reg - ddd_pkg::YEAR_W'(ddd_pkg::YEAR_W'(q_year_w)
                     * ddd_pkg::YEAR_W'(100));
        // divisible by 400 when divisible by 100 and the quotient by 4
        leap_w     = (year_reg[1:0] == 2'b00)
                     && ((rem_year_w != '0) || (q_year_w[1:0] == 2'b00));

        priority if (month_bad_reg)
            status_next = ddd_pkg::STATUS_BAD_MONTH;
        else if (day_bad_reg || (feb29_reg && !leap_w))
            status_next = ddd_pkg::STATUS_BAD_DAY;
        else
            status_next = ddd_pkg::STATUS_OK;

        tail_w = ddd_pkg::COUNT_W'(mterm_reg) + ddd_pkg::COUNT_W'(day_reg);
        if (neg_reg)
        begin
            // shifted year of minus one: no leap days
            count_next = $signed(tail_w - ddd_pkg::COUNT_W'(ddd_pkg::DAYS_PER_YEAR));
        end
        else
        begin
            count_next = $signed(
                ddd_pkg::COUNT_W'(yy_reg) * ddd_pkg::COUNT_W'(ddd_pkg::DAYS_PER_YEAR)
                + ddd_pkg::COUNT_W'(yy_reg >> 2)
                - ddd_pkg::COUNT_W'(q_yy_w)
                + ddd_pkg::COUNT_W'(q_yy_w >> 2)
                + tail_w);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s2)
        begin
            status_reg <= status_next;
            count_reg  <= count_next;
        end
    end

    assign status = status_reg;
    assign count  = count_reg;

endmodule
`default_nettype wire

/* design/date_day_difference.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// date_day_difference
// Checks two Gregorian dates and returns their difference in days.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item: two dates as binary
//   year, month and day. Output channel (out_valid / out_stall) returns one
//   item per input: the signed day difference (first minus second, clamped
//   to +/-3660000) and a status per date (valid, bad month, bad day). The
//   difference is zero when either date is bad.
//   out_valid rises once the item has moved through stages 1, 2 and 3 below;
//   one item can be taken every cycle while out_stall is low. Stage 1
//   checks ranges and forms the divide-by-100 products, stage 2 builds the
//   day counts, stage 3 subtracts and clamps into the output register.
//   When the receiver stalls, the output holds; earlier stages keep filling
//   empty slots and in_stall rises only once every stage is full.
//   Reset clears all valid bits; the pipeline comes up empty.
// ----------------------------------------------------------------------------
module date_day_difference (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [ddd_pkg::YEAR_W-1:0]          first_year,
    input  wire logic [ddd_pkg::MONTH_W-1:0]         first_month,
    input  wire logic [ddd_pkg::DAY_W-1:0]           first_day,
    input  wire logic [ddd_pkg::YEAR_W-1:0]          second_year,
    input  wire logic [ddd_pkg::MONTH_W-1:0]         second_month,
    input  wire logic [ddd_pkg::DAY_W-1:0]           second_day,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [ddd_pkg::DIFF_W-1:0]        day_difference,
    output logic [1:0]                               first_status,
    output logic [1:0]                               second_status
);

    logic v1_reg, v2_reg, v3_reg;
    logic en1_w, en2_w, en3_w;
    ddd_pkg::stage_en_t ctrl_w;

    // advance a stage when it is empty or the next one advances
    always_comb
    begin
        en3_w     = !v3_reg || !out_stall;
        en2_w     = !v2_reg || en3_w;
        en1_w     = !v1_reg || en2_w;
        ctrl_w.s1 = en1_w;
        ctrl_w.s2 = en2_w;
        in_stall  = !en1_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1_w)
                v1_reg <= in_valid;
            if (en2_w)
                v2_reg <= v1_reg;
            if (en3_w)
                v3_reg <= v2_reg;
        end
    end

    ddd_pkg::status_t                   st1_w, st2_w;
    logic signed [ddd_pkg::COUNT_W-1:0] cnt1_w, cnt2_w;

    ddd_date_conv u_first (
        .clk    (clk),
        .ctrl   (ctrl_w),
        .year   (first_year),
        .month  (first_month),
        .day    (first_day),
        .status (st1_w),
        .count  (cnt1_w)
    );

    ddd_date_conv u_second (
        .clk    (clk),
        .ctrl   (ctrl_w),
        .year   (second_year),
        .month  (second_month),
        .day    (second_day),
        .status (st2_w),
        .count  (cnt2_w)
    );

    logic signed [ddd_pkg::COUNT_W:0]    diff_w;
    logic signed [ddd_pkg::DIFF_W-1:0]   diff_reg, diff_next;
    ddd_pkg::status_t                    st1_reg, st2_reg;

    always_comb
    begin
        diff_w = {cnt1_w[ddd_pkg::COUNT_W-1], cnt1_w}
                 - {cnt2_w[ddd_pkg::COUNT_W-1], cnt2_w};
        priority if ((st1_w != ddd_pkg::STATUS_OK) || (st2_w != ddd_pkg::STATUS_OK))
            diff_next = '0;
        else if (diff_w > (ddd_pkg::COUNT_W+1)'(ddd_pkg::DIFF_LIMIT))
            diff_next = ddd_pkg::DIFF_W'(ddd_pkg::DIFF_LIMIT);
        else if (diff_w < -((ddd_pkg::COUNT_W+1)'(ddd_pkg::DIFF_LIMIT)))
            diff_next = -(ddd_pkg::DIFF_W'(ddd_pkg::DIFF_LIMIT));
        else
            diff_next = diff_w[ddd_pkg::DIFF_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en3_w)
        begin
            diff_reg <= diff_next;
            st1_reg  <= st1_w;
            st2_reg  <= st2_w;
        end
    end

    assign out_valid      = v3_reg;
    assign day_difference = diff_reg;
    assign first_status   = st1_reg;
    assign second_status  = st2_reg;

endmodule
`default_nettype wire
